@@ hw/rtl/ddf_pkg.sv @@
`timescale 1ns / 1ps

package ddf_pkg;

  // default widths of the attribute values and the class index
  localparam int ValueBitsDef = 24;
  localparam int ClassBitsDef = 8;

  // fixed field widths
  localparam int PosBits   = 9;
  localparam int CountBits = 16;
  localparam int CcBits    = 8;
  localparam int ScaleBits = 24;
  localparam int PadBits   = 23;
  localparam int BoxBits   = 16;
  localparam int CfgIdxBits = 3;

  // fraction bits of the inverse scale
  localparam int ScaleFrac = 16;
  // fraction bits of the attribute values
  localparam int ValueFrac = 8;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgThreshold  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgClassCount = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgDetCount   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgInvScale   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPadX       = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgPadY       = 3'd5;

  // register reset values
  localparam int ThresholdRst = 64;
  localparam logic [CcBits-1:0]    ClassCountRst = 8'd80;
  localparam logic [CountBits-1:0] DetCountRst   = 16'd8400;
  localparam logic [ScaleBits-1:0] InvScaleRst   = 24'd65536;

  // attribute positions within one detection
  localparam logic [PosBits-1:0] PosCx    = 9'd0;
  localparam logic [PosBits-1:0] PosCy    = 9'd1;
  localparam logic [PosBits-1:0] PosW     = 9'd2;
  localparam logic [PosBits-1:0] PosH     = 9'd3;
  localparam logic [PosBits-1:0] PosScore = 9'd4;
  // first score plus the largest class count less one
  localparam logic [PosBits-1:0] PosMax   = 9'd258;

endpackage

@@ hw/rtl/ddf_attr_if.sv @@
`timescale 1ns / 1ps

interface ddf_attr_if import ddf_pkg::*; #(
  parameter int VALUE_BITS = ValueBitsDef
) ();

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] attr_value;

  modport source (output valid, output attr_value, input ready);
  modport sink   (input valid, input attr_value, output ready);

endinterface

@@ hw/rtl/ddf_det_if.sv @@
`timescale 1ns / 1ps

interface ddf_det_if import ddf_pkg::*; #(
  parameter int VALUE_BITS = ValueBitsDef,
  parameter int CLASS_BITS = ClassBitsDef
) ();

  logic                         valid;
  logic                         ready;
  logic [CountBits-1:0]         det_index;
  logic [CLASS_BITS-1:0]        class_idx;
  logic signed [VALUE_BITS-1:0] best_score_out;
  logic signed [BoxBits-1:0]    box_left;
  logic signed [BoxBits-1:0]    box_top;
  logic signed [BoxBits-1:0]    box_width;
  logic signed [BoxBits-1:0]    box_height;

  modport source (
    output valid, output det_index, output class_idx, output best_score_out,
    output box_left, output box_top, output box_width, output box_height,
    input ready
  );
  modport sink (
    input valid, input det_index, input class_idx, input best_score_out,
    input box_left, input box_top, input box_width, input box_height,
    output ready
  );

endinterface

@@ hw/rtl/detection_decode_filter_top.sv @@
`timescale 1ns / 1ps

// detection decode filter
// in_ch takes one detector output word per beat, detection-major: centre x,
// centre y, width, height, then class_count class scores, all Q16.8.
// a running argmax (strict greater-than, first class wins ties) follows the
// scores; after the last score of a detection a beat goes out on out_ch if
// the best score is above score_threshold. it carries the detection index,
// class, score and the corner box rescaled to original image pixels
// throughput: one input beat per cycle; in_ch.ready only drops when a
// result is waiting in every stage of the box pipe and out_ch is stalled
// after the edge that takes the last class score, the result passes the
// truncate/pad stage, the multiply stage and the rescale (output) register
// to reach out_ch; the multiply stage has four multipliers, one per box edge
// config is written via cfg_we_i / cfg_index_i / cfg_wdata_i, one register
// per edge; the user writes only while no result is in flight (unenforced)
// reset clears the position, argmax, detection counter and pipe valids, and
// loads the register defaults (threshold 0.25, 80 classes, 8400 detections,
// unit scale, no padding)
// when out_ch stalls, bubbles in the box pipe still close up, so beats that
// raise no result keep flowing
module detection_decode_filter_top import ddf_pkg::*; #(
  parameter int VALUE_BITS = ValueBitsDef,
  parameter int CLASS_BITS = ClassBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [((VALUE_BITS > ScaleBits) ? VALUE_BITS : ScaleBits)-1:0] cfg_wdata_i,
  ddf_attr_if.sink              in_ch,
  ddf_det_if.source             out_ch
);

  localparam int V = VALUE_BITS;
  // centre difference 2*c - size
  localparam int DW = V + 2;
  // box value minus pad, Q18.8
  localparam int PW = ((V > PadBits) ? V : PadBits) + 2;
  // product with the unsigned inverse scale
  localparam int ProdW = PW + ScaleBits + 1;
  // truncating shifts
  localparam int HalfShift = ValueFrac + 1;
  localparam int RescaleShift = ValueFrac + ScaleFrac;

  localparam logic signed [V-1:0]     MinusOne    = -(V'(1) << ValueFrac);
  localparam logic signed [DW-1:0]    BiasHalf    = DW'((1 << HalfShift) - 1);
  localparam logic signed [V:0]       BiasPix     = (V+1)'((1 << ValueFrac) - 1);
  localparam logic signed [ProdW-1:0] BiasRescale = ProdW'((1 << RescaleShift) - 1);
  localparam logic signed [ProdW-1:0] SatHi       = ProdW'((1 << (BoxBits - 1)) - 1);
  localparam logic signed [ProdW-1:0] SatLo       = -(ProdW'(1) << (BoxBits - 1));

  typedef struct packed {
    logic [CountBits-1:0]  idx;
    logic [CLASS_BITS-1:0] cls;
    logic signed [V-1:0]   score;
  } meta_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [V-1:0]  threshold_q;
  logic [CcBits-1:0]    class_count_q;
  logic [CountBits-1:0] det_count_q;
  logic [ScaleBits-1:0] inv_scale_q;
  logic [PadBits-1:0]   pad_x_q;
  logic [PadBits-1:0]   pad_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= V'(ThresholdRst);
      class_count_q <= ClassCountRst;
      det_count_q   <= DetCountRst;
      inv_scale_q   <= InvScaleRst;
      pad_x_q       <= '0;
      pad_y_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgThreshold:  threshold_q   <= cfg_wdata_i[V-1:0];
        CfgClassCount: class_count_q <= cfg_wdata_i[CcBits-1:0];
        CfgDetCount:   det_count_q   <= cfg_wdata_i[CountBits-1:0];
        CfgInvScale:   inv_scale_q   <= cfg_wdata_i[ScaleBits-1:0];
        CfgPadX:       pad_x_q       <= cfg_wdata_i[PadBits-1:0];
        CfgPadY:       pad_y_q       <= cfg_wdata_i[PadBits-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipe enables: each stage moves when it is empty or its successor moves
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, en_out;

  assign en_out = !out_valid_q || out_ch.ready;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign in_ch.ready = en1;

  logic accept;
  assign accept = in_ch.valid && en1;

  // ---------------------------------------------------------------------
  // detection state and running argmax
  // ---------------------------------------------------------------------
  logic [PosBits-1:0]    attr_pos_q;
  logic signed [V-1:0]   best_score_q;
  logic [CLASS_BITS-1:0] best_class_q;
  logic signed [V-1:0]   center_x_q, center_y_q, raw_w_q, raw_h_q;
  logic [CountBits-1:0]  det_cnt_q;

  logic                  is_score;
  logic [PosBits-1:0]    class_pos;
  logic [CcBits-1:0]     classes;
  logic                  last_score;
  logic                  upd;
  logic signed [V-1:0]   cand_score;
  logic [CLASS_BITS-1:0] cand_class;
  logic [CountBits-1:0]  cnt_next;
  logic                  emit;

  always_comb begin
    is_score   = (attr_pos_q >= PosScore);
    class_pos  = attr_pos_q - PosScore;
    // a zero class count counts as one class
    classes    = (class_count_q == '0) ? CcBits'(1) : class_count_q;
    last_score = ({1'b0, class_pos[CcBits-1:0]} + 9'd1) >= {1'b0, classes};
    upd        = in_ch.attr_value > best_score_q;
    cand_score = upd ? in_ch.attr_value : best_score_q;
    cand_class = upd ? CLASS_BITS'(class_pos) : best_class_q;
    cnt_next   = det_cnt_q + CountBits'(1);
    emit       = is_score && last_score && (cand_score > threshold_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_pos_q   <= '0;
      best_score_q <= MinusOne;
      best_class_q <= '0;
      center_x_q   <= '0;
      center_y_q   <= '0;
      raw_w_q      <= '0;
      raw_h_q      <= '0;
      det_cnt_q    <= '0;
    end else if (accept) begin
      case (attr_pos_q)
        PosCx: begin
          center_x_q <= in_ch.attr_value;
          attr_pos_q <= PosCy;
        end
        PosCy: begin
          center_y_q <= in_ch.attr_value;
          attr_pos_q <= PosW;
        end
        PosW: begin
          raw_w_q    <= in_ch.attr_value;
          attr_pos_q <= PosH;
        end
        PosH: begin
          raw_h_q    <= in_ch.attr_value;
          attr_pos_q <= PosScore;
        end
        default: begin
          if (last_score) begin
            // end of detection: start a fresh argmax
            attr_pos_q   <= PosCx;
            best_score_q <= MinusOne;
            best_class_q <= '0;
            det_cnt_q    <= (cnt_next >= det_count_q) ? '0 : cnt_next;
          end else begin
            attr_pos_q   <= attr_pos_q + PosBits'(1);
            best_score_q <= cand_score;
            best_class_q <= cand_class;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: centre differences and sizes of a passing detection
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;
  logic signed [V-1:0]  s1_w_q, s1_h_q;
  meta_t                s1_meta_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_dx_q   <= $signed({center_x_q[V-1], center_x_q, 1'b0})
                 - $signed({{2{raw_w_q[V-1]}}, raw_w_q});
      s1_dy_q   <= $signed({center_y_q[V-1], center_y_q, 1'b0})
                 - $signed({{2{raw_h_q[V-1]}}, raw_h_q});
      s1_w_q    <= raw_w_q;
      s1_h_q    <= raw_h_q;
      s1_meta_q <= '{idx: det_cnt_q, cls: cand_class, score: cand_score};
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: truncate to whole pixels and take off the letterbox pad
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] s2_l_q, s2_t_q, s2_w_q, s2_h_q;
  meta_t                s2_meta_q;

  logic signed [DW-1:0] bx, by, lx8, ty8;
  logic signed [V:0]    bw, bh, w8, h8;

  always_comb begin
    // truncation toward zero: bias negative values before the shift
    bx  = s1_dx_q + (s1_dx_q[DW-1] ? BiasHalf : '0);
    by  = s1_dy_q + (s1_dy_q[DW-1] ? BiasHalf : '0);
    lx8 = (bx >>> HalfShift) <<< ValueFrac;
    ty8 = (by >>> HalfShift) <<< ValueFrac;
    bw  = (V+1)'(s1_w_q) + (s1_w_q[V-1] ? BiasPix : '0);
    bh  = (V+1)'(s1_h_q) + (s1_h_q[V-1] ? BiasPix : '0);
    w8  = (bw >>> ValueFrac) <<< ValueFrac;
    h8  = (bh >>> ValueFrac) <<< ValueFrac;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_l_q    <= PW'(lx8) - $signed({{(PW-PadBits){1'b0}}, pad_x_q});
      s2_t_q    <= PW'(ty8) - $signed({{(PW-PadBits){1'b0}}, pad_y_q});
      s2_w_q    <= PW'(w8);
      s2_h_q    <= PW'(h8);
      s2_meta_q <= s1_meta_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: multiply by the inverse scale, one multiplier per edge
  // ---------------------------------------------------------------------
  logic signed [ProdW-1:0]    s3_l_q, s3_t_q, s3_w_q, s3_h_q;
  logic signed [ScaleBits:0]  scale_s;
  meta_t                      s3_meta_q;

  assign scale_s = $signed({1'b0, inv_scale_q});

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_l_q    <= ProdW'(s2_l_q) * ProdW'(scale_s);
      s3_t_q    <= ProdW'(s2_t_q) * ProdW'(scale_s);
      s3_w_q    <= ProdW'(s2_w_q) * ProdW'(scale_s);
      s3_h_q    <= ProdW'(s2_h_q) * ProdW'(scale_s);
      s3_meta_q <= s2_meta_q;
    end
  end

  // ---------------------------------------------------------------------
  // output register: truncating rescale and saturation to 16 bits
  // ---------------------------------------------------------------------
  function automatic logic signed [BoxBits-1:0] rescale_sat(
    input logic signed [ProdW-1:0] prod
  );
    logic signed [ProdW-1:0] biased;
    logic signed [ProdW-1:0] pix;
    begin
      biased = prod + (prod[ProdW-1] ? BiasRescale : '0);
      pix    = biased >>> RescaleShift;
      if (pix > SatHi) begin
        rescale_sat = SatHi[BoxBits-1:0];
      end else if (pix < SatLo) begin
        rescale_sat = SatLo[BoxBits-1:0];
      end else begin
        rescale_sat = pix[BoxBits-1:0];
      end
    end
  endfunction

  meta_t                     out_meta_q;
  logic signed [BoxBits-1:0] out_l_q, out_t_q, out_w_q, out_h_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_meta_q <= s3_meta_q;
      out_l_q    <= rescale_sat(s3_l_q);
      out_t_q    <= rescale_sat(s3_t_q);
      out_w_q    <= rescale_sat(s3_w_q);
      out_h_q    <= rescale_sat(s3_h_q);
    end
  end

  // pipe valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept && emit;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.det_index      = out_meta_q.idx;
  assign out_ch.class_idx      = out_meta_q.cls;
  assign out_ch.best_score_out = out_meta_q.score;
  assign out_ch.box_left       = out_l_q;
  assign out_ch.box_top        = out_t_q;
  assign out_ch.box_width      = out_w_q;
  assign out_ch.box_height     = out_h_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    attr_pos_q <= PosMax)
    else $error("attribute position beyond the last class score");

  a_argmax_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_score && last_score) |=>
      (best_score_q == MinusOne) && (best_class_q == '0) && (attr_pos_q == PosCx))
    else $error("argmax not restarted after the last class score");

  a_pipe_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("result lost between stage 1 and stage 2");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v3_q))
    else $error("result beat raised with no result in the multiply stage");

endmodule

@@ verif/detection_decode_filter_top_tb.sv @@
`timescale 1ns / 1ps

// stream check of the detection decode filter: words go in as whole
// detections (box then class scores), each accepted beat is decoded by a
// local copy of the argmax, threshold and box rescale, and every result beat
// is checked field by field against the oldest detection that passed
module detection_decode_filter_top_tb;
  import ddf_pkg::*;

  localparam int CfgBits = (ValueBitsDef > ScaleBits) ? ValueBitsDef : ScaleBits;
  // a write to this index must leave every register as it was
  localparam logic [CfgIdxBits-1:0] CfgUnused = 3'd6;

  // cycles to let the box pipe settle before touching config
  localparam int SettleCycles  = 8;
  // longest pause that either side draws before its next beat
  localparam int MaxGap        = 11;
  // long stall of the result side so the pipe fills and in_ch backs up
  localparam int SqueezeCycles = 500;
  // cycles with no beat on either channel before the run is declared hung
  localparam int QuietLimit    = 2500;
  localparam int RandomItems   = 1350;
  // Q8.16 scale times Q16.8 value leaves 24 fraction bits
  localparam longint PixelDiv  = 64'sd16777216;

  typedef struct packed {
    logic [CountBits-1:0]    det_index;
    logic [ClassBitsDef-1:0] class_idx;
    logic [ValueBitsDef-1:0] score;
    logic [BoxBits-1:0]      box_l;
    logic [BoxBits-1:0]      box_t;
    logic [BoxBits-1:0]      box_w;
    logic [BoxBits-1:0]      box_h;
  } det_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [CfgBits-1:0]    cfg_wdata;

  ddf_attr_if #(.VALUE_BITS(ValueBitsDef)) attr_ch ();
  ddf_det_if #(.VALUE_BITS(ValueBitsDef), .CLASS_BITS(ClassBitsDef)) det_ch ();

  detection_decode_filter_top #(
    .VALUE_BITS(ValueBitsDef),
    .CLASS_BITS(ClassBitsDef)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (attr_ch),
    .out_ch      (det_ch)
  );

  always #10 clk_i = ~clk_i;

  // words waiting to be offered on in_ch, and detections that passed the
  // threshold and still wait for their result beat
  logic [ValueBitsDef-1:0] attr_words[$];
  det_beat_t               kept_dets[$];

  // local copy of the registers
  longint                thr_q;
  int                    class_cnt;
  logic [CountBits-1:0]  det_limit;
  longint                inv_scale;
  longint                pad_x_q;
  longint                pad_y_q;

  // local copy of the decode state
  logic [PosBits-1:0]    attr_pos;
  longint                best_q;
  logic [ClassBitsDef-1:0] best_cls;
  longint                cx_q, cy_q, rw_q, rh_q;
  logic [CountBits-1:0]  det_cnt;

  int  mismatches   = 0;
  int  send_wait    = 0;
  int  recv_wait    = 0;
  int  hold_left    = 0;
  int  quiet_cycles = 0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;
  bit  squeeze      = 1'b0;
  bit  squeeze_done = 1'b0;
  det_beat_t head_det;

  // append one word to the send queue
  function automatic void add_word(input logic [ValueBitsDef-1:0] word);
    attr_words = {attr_words, word};
  endfunction

  // Q16.8 value to whole original-image pixels, truncated then clamped
  function automatic logic [BoxBits-1:0] to_pixels(input longint q8);
    longint pix;
    pix = (q8 * inv_scale) / PixelDiv;
    if (pix > 32767) pix = 32767;
    else if (pix < -32768) pix = -32768;
    return pix[BoxBits-1:0];
  endfunction

  // one accepted word through position tracking, argmax and threshold
  function automatic void decode_attr(input logic [ValueBitsDef-1:0] word);
    longint v, left_i, top_i, w_i, h_i;
    int classes, j;
    logic [CountBits-1:0] next_idx;
    det_beat_t rec;
    v = longint'($signed(word));
    classes = (class_cnt == 0) ? 1 : class_cnt;
    case (attr_pos)
      PosCx: begin
        cx_q = v;
        attr_pos = PosCy;
        return;
      end
      PosCy: begin
        cy_q = v;
        attr_pos = PosW;
        return;
      end
      PosW: begin
        rw_q = v;
        attr_pos = PosH;
        return;
      end
      PosH: begin
        rh_q = v;
        attr_pos = PosScore;
        return;
      end
      default: ;
    endcase

    j = int'(attr_pos) - int'(PosScore);
    // strict compare keeps the first class on a tie
    if (v > best_q) begin
      best_q = v;
      best_cls = j[ClassBitsDef-1:0];
    end
    if (j + 1 < classes) begin
      attr_pos = attr_pos + 1'b1;
      return;
    end

    // last score of the detection: step the frame counter
    rec.det_index = det_cnt;
    next_idx = det_cnt + 1'b1;
    det_cnt = (next_idx >= det_limit) ? '0 : next_idx;
    attr_pos = PosCx;

    if (best_q > thr_q) begin
      left_i = (2 * cx_q - rw_q) / 512;
      top_i  = (2 * cy_q - rh_q) / 512;
      w_i    = rw_q / 256;
      h_i    = rh_q / 256;
      rec.class_idx = best_cls;
      rec.score     = best_q[ValueBitsDef-1:0];
      rec.box_l     = to_pixels(left_i * 256 - pad_x_q);
      rec.box_t     = to_pixels(top_i * 256 - pad_y_q);
      rec.box_w     = to_pixels(w_i * 256);
      rec.box_h     = to_pixels(h_i * 256);
      kept_dets = {kept_dets, rec};
    end
    best_q = -256;
    best_cls = '0;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // mostly a value in [lo, hi], now and then a full-range word or an extreme
  function automatic logic [ValueBitsDef-1:0] pick_word(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return ValueBitsDef'($urandom);
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return ValueBitsDef'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // mode 1 forces the low end, mode 2 the high end, otherwise random
  function automatic logic [CfgBits-1:0] pick_setting(input logic [CfgBits-1:0] lo_end,
      input logic [CfgBits-1:0] hi_end, input int lo, input int hi, input int mode);
    if (mode == 1) return lo_end;
    if (mode == 2) return hi_end;
    case ($urandom_range(0, 7))
      0: return lo_end;
      1: return hi_end;
      default: return CfgBits'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  task automatic set_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CfgThreshold:  thr_q = longint'($signed(val[ValueBitsDef-1:0]));
      CfgClassCount: class_cnt = int'(val[CcBits-1:0]);
      CfgDetCount:   det_limit = val[CountBits-1:0];
      CfgInvScale:   inv_scale = longint'(val[ScaleBits-1:0]);
      CfgPadX:       pad_x_q = longint'(val[PadBits-1:0]);
      CfgPadY:       pad_y_q = longint'(val[PadBits-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // idle means nothing queued or offered and no result outstanding; checked
  // on the falling edge so the driver's updates of this cycle are visible
  task automatic wait_drained();
    do @(negedge clk_i);
    while (attr_words.size() != 0 || attr_ch.valid || kept_dets.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // box words near a 1280-pixel frame, scores around the threshold, with
  // repeated scores now and then to hit ties
  task automatic queue_detection(input int n_scores);
    logic [ValueBitsDef-1:0] score;
    add_word(pick_word(-2560, 327680));
    add_word(pick_word(-2560, 327680));
    add_word(pick_word(-512, 102400));
    add_word(pick_word(-512, 102400));
    score = pick_word(-1024, 1024);
    for (int i = 0; i < n_scores; i++) begin
      if (i == 0 || $urandom_range(0, 7) != 0) score = pick_word(-1024, 1024);
      add_word(score);
    end
  endtask

  task automatic configure_phase(input int mode);
    int cc;
    if (mode != 0 || $urandom_range(0, 2) != 0)
      set_reg(CfgThreshold, pick_setting(24'h800000, 24'h7FFFFF, -512, 512, mode));
    if (mode != 0 || $urandom_range(0, 2) != 0) begin
      if (mode == 1) cc = 1;
      else if (mode == 2) cc = 255;
      else if ($urandom_range(0, 15) == 0) cc = $urandom_range(100, 255);
      else if ($urandom_range(0, 3) == 0) cc = $urandom_range(7, 40);
      else cc = $urandom_range(1, 6);
      set_reg(CfgClassCount, CfgBits'(cc));
    end
    if (mode != 0 || $urandom_range(0, 2) != 0)
      set_reg(CfgDetCount, pick_setting(24'd1, 24'd65535, 1, 6, mode));
    if (mode != 0 || $urandom_range(0, 2) != 0)
      set_reg(CfgInvScale, pick_setting(24'd0, 24'hFFFFFF, 32768, 131072, mode));
    if (mode != 0 || $urandom_range(0, 2) != 0)
      set_reg(CfgPadX, pick_setting(24'd0, 24'h7FFFFF, 0, 20480, mode));
    if (mode != 0 || $urandom_range(0, 2) != 0)
      set_reg(CfgPadY, pick_setting(24'd0, 24'h7FFFFF, 0, 20480, mode));
  endtask

  // driver: offers queued words, holds a word until taken, then draws a gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      attr_ch.valid      <= 1'b0;
      attr_ch.attr_value <= '0;
    end else begin
      if (attr_ch.valid && attr_ch.ready) begin
        decode_attr(attr_ch.attr_value);
        send_wait = tx_calm ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      end
      // a word on offer that was not taken stays as it is
      if (!(attr_ch.valid && !attr_ch.ready)) begin
        if (send_wait > 0) begin
          send_wait--;
          attr_ch.valid <= 1'b0;
        end else if (attr_words.size() > 0) begin
          attr_ch.valid      <= 1'b1;
          attr_ch.attr_value <= attr_words.pop_front();
        end else begin
          attr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat, then draws its own pause; one long
  // hold-off when the squeeze phase starts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      det_ch.ready <= 1'b0;
    end else begin
      if (det_ch.valid && det_ch.ready) begin
        if (kept_dets.size() == 0) begin
          $error("result beat with no detection pending, det_index %0d", det_ch.det_index);
          mismatches++;
        end else begin
          head_det = kept_dets.pop_front();
          check_field("det_index", head_det.det_index, det_ch.det_index);
          check_field("class_idx", head_det.class_idx, det_ch.class_idx);
          check_field("best_score_out", $signed(head_det.score), det_ch.best_score_out);
          check_field("box_left", $signed(head_det.box_l), det_ch.box_left);
          check_field("box_top", $signed(head_det.box_t), det_ch.box_top);
          check_field("box_width", $signed(head_det.box_w), det_ch.box_width);
          check_field("box_height", $signed(head_det.box_h), det_ch.box_height);
        end
        recv_wait = rx_calm ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      end
      if (squeeze && !squeeze_done) begin
        hold_left = SqueezeCycles;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        det_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        det_ch.ready <= 1'b0;
      end else begin
        det_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on beats of either channel
  always @(posedge clk_i) begin
    if ((attr_ch.valid && attr_ch.ready) || (det_ch.valid && det_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int random_items;
    int phase_no;
    int n_det;

    // reset held low, config port idle
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // register defaults and cleared decode state
    thr_q     = ThresholdRst;
    class_cnt = int'(ClassCountRst);
    det_limit = DetCountRst;
    inv_scale = longint'(InvScaleRst);
    pad_x_q   = 0;
    pad_y_q   = 0;
    attr_pos  = PosCx;
    best_q    = -256;
    best_cls  = '0;
    cx_q      = 0;
    cy_q      = 0;
    rw_q      = 0;
    rh_q      = 0;
    det_cnt   = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // directed: two classes, frames of two detections
    set_reg(CfgThreshold, CfgBits'(ThresholdRst));
    set_reg(CfgClassCount, 24'd2);
    set_reg(CfgDetCount, 24'd2);
    set_reg(CfgInvScale, 24'd65536);
    set_reg(CfgPadX, 24'd768);
    set_reg(CfgPadY, 24'd384);
    // tied scores above threshold: class 0 wins
    add_word(24'd25728);
    add_word(24'd12800);
    add_word(24'd5576);
    add_word(24'd2561);
    add_word(24'd200);
    add_word(24'd200);
    // no score above minus one, below threshold: dropped, counter wraps
    add_word(-24'sd1280);
    add_word(24'd3);
    add_word(-24'sd700);
    add_word(24'd0);
    add_word(-24'sd256);
    add_word(-24'sd256);
    // extreme box and scores, index back at zero
    add_word(24'h7FFFFF);
    add_word(24'h800000);
    add_word(24'h800000);
    add_word(24'h7FFFFF);
    add_word(24'h800000);
    add_word(24'h7FFFFF);
    wait_drained();

    // threshold below minus one: result with class 0 and score -1.0,
    // largest scale and pad so the box saturates; unknown index ignored
    set_reg(CfgThreshold, 24'h800000);
    set_reg(CfgClassCount, 24'd1);
    set_reg(CfgInvScale, 24'hFFFFFF);
    set_reg(CfgPadX, 24'h7FFFFF);
    set_reg(CfgPadY, 24'd0);
    set_reg(CfgUnused, 24'h123456);
    add_word(24'd0);
    add_word(-24'sd1);
    add_word(24'h7FFFFF);
    add_word(24'h7FFFFF);
    add_word(24'h800000);
    wait_drained();

    // class count lowered below the running position: the next score ends
    // the detection
    set_reg(CfgInvScale, 24'd65536);
    set_reg(CfgPadX, 24'd0);
    set_reg(CfgClassCount, 24'd20);
    queue_detection(10);
    wait_drained();
    set_reg(CfgClassCount, 24'd3);
    add_word(pick_word(-1024, 1024));
    random_items = 15;
    wait_drained();

    // squeeze: every detection passes, result side holds off for a long
    // stretch while words keep coming
    set_reg(CfgThreshold, 24'h800000);
    set_reg(CfgClassCount, 24'd1);
    set_reg(CfgDetCount, CfgBits'($urandom_range(1, 9)));
    squeeze = 1'b1;
    for (int i = 0; i < 60; i++) queue_detection(1);
    random_items += 300;

    // random phases, the first at the low ends of every register and the
    // second at the high ends
    phase_no = 0;
    while (random_items < RandomItems) begin
      wait_drained();
      configure_phase((phase_no < 2) ? phase_no + 1 : 0);
      n_det = (class_cnt > 40) ? 1 : $urandom_range(2, 12);
      for (int i = 0; i < n_det; i++) begin
        queue_detection(class_cnt);
        random_items += 4 + class_cnt;
      end
      phase_no++;
    end

    wait_drained();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
